FILE: src/utf8_stream_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define UTF8SD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("utf8 decoder check failed");

// Condition that must never be seen outside reset.
`define UTF8SD_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("utf8 decoder forbidden condition seen");

`else

`define UTF8SD_ASSERT(lbl, clk, rstn, prop)
`define UTF8SD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: src/utf8sd_pkg.sv
// Constants and types for the UTF-8 stream decoder.
package utf8sd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POINT_W = 21;
	localparam int unsigned DUE_W   = 2;
	localparam int unsigned OUT_TDATA_W = ((POINT_W + 7) / 8) * 8;

	// lead and continuation tags, top bits of a byte
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	localparam logic [DUE_W-1:0] DUE_NONE = 2'd0;
	localparam logic [DUE_W-1:0] DUE_ONE  = 2'd1;
	localparam logic [DUE_W-1:0] DUE_TWO  = 2'd2;
	localparam logic [DUE_W-1:0] DUE_THREE = 2'd3;

	typedef struct packed {
		logic [POINT_W-1:0] partial;
		logic [DUE_W-1:0]   due;
		logic               bad;
	} dec_state_t;

	typedef struct packed {
		logic [POINT_W-1:0] code_point;
		logic               point_valid;
		logic               string_end;
	} dec_result_t;

endpackage

FILE: src/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: byte in, code point out.
//
// Usage:
//   Slave side (s_*) takes one byte of UTF-8 text per word; s_tlast marks the
//   final byte of a string. Master side (m_*) gives exactly one word per input
//   word: m_tdata carries the code point, m_tuser[0] says whether this byte
//   completed a well-formed sequence (code point is zero otherwise), and
//   m_tlast echoes the input's last flag.
//   Output: m_tvalid rises once an accepted word has passed the input register
//   and then the decode step into the result register; a receiver stall can
//   hold the word in the input register before that step.
//   Throughput: one word per cycle while the receiver does not stall, set by the
//   single decode step that reads the sequence state and writes it back in the same cycle.
//   Reset (arst_n low) empties both registers and clears the partial code
//   point, the count of continuation bytes due and the bad-sequence mark.
//   Receiver stall: the result register holds; the input register may still
//   fill, after which s_tready drops until m_tready returns. No word is lost.
//   Sequence state also clears after every byte flagged last.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [utf8sd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [utf8sd_pkg::OUT_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic [0:0]  m_tuser,   // [0] point_valid
	output logic        m_tlast    // string_end
);

	// input register
	logic                              valid_s1;
	logic [utf8sd_pkg::BYTE_W-1:0]     byte_s1;
	logic                              last_s1;

	// result register
	logic                              valid_s2;
	utf8sd_pkg::dec_result_t           res_s2;

	// sequence state
	utf8sd_pkg::dec_state_t            state_q;
	utf8sd_pkg::dec_state_t            state_n;
	utf8sd_pkg::dec_result_t           res_n;

	logic adv_s2;   // result register takes a new word
	logic acc_in;   // input word accepted

	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign acc_in   = s_tvalid && s_tready;

	// decode step: input register + state -> next state + result
	always_comb begin
		logic cont;
		logic emit;
		logic [utf8sd_pkg::POINT_W-1:0] point;
		state_n = state_q;
		cont    = (byte_s1[7:6] == utf8sd_pkg::CONT_TAG);
		emit    = 1'b0;
		point   = '0;
		if (state_q.due != utf8sd_pkg::DUE_NONE) begin
			// any byte counts as a promised one; a bad one poisons the sequence
			if (!cont) begin
				state_n.bad = 1'b1;
			end else begin
				state_n.partial = {state_q.partial[utf8sd_pkg::POINT_W-7:0], byte_s1[5:0]};
			end
			state_n.due = state_q.due - utf8sd_pkg::DUE_ONE;
			if (state_n.due == utf8sd_pkg::DUE_NONE && !state_n.bad) begin
				emit  = 1'b1;
				point = state_n.partial;
			end
		end else if (!byte_s1[7]) begin
			emit  = 1'b1;
			point = {{(utf8sd_pkg::POINT_W-utf8sd_pkg::BYTE_W){1'b0}}, byte_s1};
		end else if (byte_s1[7:5] == utf8sd_pkg::LEAD2_TAG) begin
			state_n.partial = {{(utf8sd_pkg::POINT_W-5){1'b0}}, byte_s1[4:0]};
			state_n.due     = utf8sd_pkg::DUE_ONE;
			state_n.bad     = 1'b0;
		end else if (byte_s1[7:4] == utf8sd_pkg::LEAD3_TAG) begin
			state_n.partial = {{(utf8sd_pkg::POINT_W-4){1'b0}}, byte_s1[3:0]};
			state_n.due     = utf8sd_pkg::DUE_TWO;
			state_n.bad     = 1'b0;
		end else if (byte_s1[7:3] == utf8sd_pkg::LEAD4_TAG) begin
			state_n.partial = {{(utf8sd_pkg::POINT_W-3){1'b0}}, byte_s1[2:0]};
			state_n.due     = utf8sd_pkg::DUE_THREE;
			state_n.bad     = 1'b0;
		end
		// stray continuation or 11111xxx with nothing due: skipped

		if (emit && state_n.due == utf8sd_pkg::DUE_NONE) begin
			state_n.partial = '0;
			state_n.bad     = 1'b0;
		end
		if (last_s1) begin
			state_n = '0;   // cut-off sequence dropped, string closed
		end

		res_n.code_point  = point;
		res_n.point_valid = emit;
		res_n.string_end  = last_s1;
	end

	// control and sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (acc_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= 1'b1;
				state_q  <= state_n;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (acc_in) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv_s2) begin
			res_s2 <= res_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(utf8sd_pkg::OUT_TDATA_W-utf8sd_pkg::POINT_W){1'b0}}, res_s2.code_point};
	assign m_tuser  = res_s2.point_valid;
	assign m_tlast  = res_s2.string_end;

	// checks
	`UTF8SD_ASSERT(a_zero_when_invalid, clk, arst_n,
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
	`UTF8SD_ASSERT(a_clear_after_last, clk, arst_n,
		(adv_s2 && last_s1) |=> (state_q == '0))
	`UTF8SD_ASSERT(a_last_follows_word, clk, arst_n,
		adv_s2 |=> (m_tlast == $past(last_s1)))
	`UTF8SD_ASSERT_NEVER(a_ready_only_on_stall, clk, arst_n,
		!s_tready && !(valid_s1 && valid_s2 && !m_tready))

endmodule

FILE: sim/utf8_stream_decoder_test.sv
// Self-checking testbench for the UTF-8 stream decoder: directed table, then random strings.
`timescale 1ns / 100ps

module utf8_stream_decoder_test;

	localparam int PROBE_COUNT  = 23;
	localparam int RANDOM_WORDS = 1350;

	// one row of the directed table; when known is set the row's own result is used
	typedef struct packed {
		logic [7:0]                     data;
		logic                           last;
		logic                           known;
		logic [utf8sd_pkg::POINT_W-1:0] point;
		logic                           valid;
	} probe_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] data_byte
	logic        s_tlast;    // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // [20:0] code_point, [23:21] zero
	logic [0:0]  m_tuser;    // [0] point_valid
	logic        m_tlast;    // string_end

	utf8sd_pkg::dec_state_t  model_st;           // decoder state as the predictor sees it
	utf8sd_pkg::dec_result_t expected_words[$];  // results still owed by the block, oldest first
	logic [7:0]  text_bytes[$];         // bytes of the random string being built
	probe_row_t  probe_rows[PROBE_COUNT];
	int          fail_count = 0;
	logic        quiet_in  = 1'b0;      // stretches with no sender gaps
	logic        quiet_out = 1'b0;      // stretches with no receiver stalls

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Predict the result of one byte and advance the decoder state.
	function automatic utf8sd_pkg::dec_result_t decode_byte(input logic [7:0] b,
			input logic last);
		utf8sd_pkg::dec_result_t res;
		res = '0;
		if (model_st.due != utf8sd_pkg::DUE_NONE) begin
			// every byte counts toward the promised ones, good or not
			if (b[7:6] != utf8sd_pkg::CONT_TAG)
				model_st.bad = 1'b1;
			else
				model_st.partial = {model_st.partial[utf8sd_pkg::POINT_W-7:0], b[5:0]};
			model_st.due = model_st.due - utf8sd_pkg::DUE_ONE;
			if (model_st.due == utf8sd_pkg::DUE_NONE && !model_st.bad) begin
				res.point_valid = 1'b1;
				res.code_point  = model_st.partial;
			end
		end else if (!b[7]) begin
			res.point_valid = 1'b1;
			res.code_point  = utf8sd_pkg::POINT_W'(b);
		end else if (b[7:5] == utf8sd_pkg::LEAD2_TAG) begin
			model_st.partial = utf8sd_pkg::POINT_W'(b[4:0]);
			model_st.due     = utf8sd_pkg::DUE_ONE;
			model_st.bad     = 1'b0;
		end else if (b[7:4] == utf8sd_pkg::LEAD3_TAG) begin
			model_st.partial = utf8sd_pkg::POINT_W'(b[3:0]);
			model_st.due     = utf8sd_pkg::DUE_TWO;
			model_st.bad     = 1'b0;
		end else if (b[7:3] == utf8sd_pkg::LEAD4_TAG) begin
			model_st.partial = utf8sd_pkg::POINT_W'(b[2:0]);
			model_st.due     = utf8sd_pkg::DUE_THREE;
			model_st.bad     = 1'b0;
		end
		// stray continuation or 11111xxx with nothing due: skipped
		if (res.point_valid && model_st.due == utf8sd_pkg::DUE_NONE) begin
			model_st.partial = '0;
			model_st.bad     = 1'b0;
		end
		if (last)
			model_st = '0;
		res.string_end = last;
		return res;
	endfunction

	// Mostly zero, often short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Add one byte at the end of the string being built.
	task automatic append_byte(input logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endtask

	// Append one sequence of len bytes; spoil swaps one continuation for a random byte.
	task automatic push_sequence(input int len, input bit spoil);
		int bad_at;
		bad_at = spoil ? $urandom_range(1, len - 1) : 0;
		case (len)
			1: append_byte({1'b0, 7'($urandom)});
			2: append_byte({utf8sd_pkg::LEAD2_TAG, 5'($urandom)});
			3: append_byte({utf8sd_pkg::LEAD3_TAG, 4'($urandom)});
			default: append_byte({utf8sd_pkg::LEAD4_TAG, 3'($urandom)});
		endcase
		for (int k = 1; k < len; k++) begin
			if (spoil && k == bad_at)
				append_byte(8'($urandom));
			else
				append_byte({utf8sd_pkg::CONT_TAG, 6'($urandom)});
		end
	endtask

	// Build one random string: well-formed sequences with some noise mixed in.
	task automatic fill_string();
		int n_points;
		int kind;
		int cut;
		text_bytes.delete();
		n_points = $urandom_range(1, 10);
		repeat (n_points) begin
			kind = $urandom_range(0, 99);
			if (kind < 25)
				push_sequence(1, 1'b0);
			else if (kind < 45)
				push_sequence(2, 1'b0);
			else if (kind < 65)
				push_sequence(3, 1'b0);
			else if (kind < 80)
				push_sequence(4, 1'b0);
			else if (kind < 88) begin
				// stray lead: lone continuation or 11111xxx
				if ($urandom_range(0, 1))
					append_byte({utf8sd_pkg::CONT_TAG, 6'($urandom)});
				else
					append_byte({5'b11111, 3'($urandom)});
			end else if (kind < 95)
				push_sequence($urandom_range(2, 4), 1'b1);
			else
				append_byte(8'($urandom));
		end
		// sometimes end the string early, often in the middle of a sequence
		if ($urandom_range(0, 9) == 0 && text_bytes.size() > 1) begin
			cut = $urandom_range(1, text_bytes.size() - 1);
			repeat (cut) void'(text_bytes.pop_back());
		end
	endtask

	// Offer one word and hold it until taken. The expectation is queued first,
	// so it is always in place before the result can show up.
	task automatic send_word(input logic [7:0] b, input logic last,
			input utf8sd_pkg::dec_result_t fixed, input bit use_fixed);
		utf8sd_pkg::dec_result_t predicted;
		int gap;
		predicted = decode_byte(b, last);
		expected_words.insert(expected_words.size(), use_fixed ? fixed : predicted);
		gap = quiet_in ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stimulus: reset, directed table, random strings, then drain.
	initial begin
		int sent;
		utf8sd_pkg::dec_result_t fixed;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		model_st = '0;
		probe_rows = '{
			'{8'h00, 1'b0, 1'b1, 21'h000000, 1'b1},  // smallest one-byte point
			'{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b1},  // largest one-byte point
			'{8'h80, 1'b0, 1'b1, 21'h000000, 1'b0},  // stray continuation
			'{8'hFF, 1'b0, 1'b1, 21'h000000, 1'b0},  // 11111xxx lead, skipped
			'{8'hDF, 1'b0, 1'b1, 21'h000000, 1'b0},
			'{8'hBF, 1'b0, 1'b1, 21'h0007FF, 1'b1},  // top of two-byte range
			'{8'hEF, 1'b0, 1'b1, 21'h000000, 1'b0},
			'{8'hBF, 1'b0, 1'b1, 21'h000000, 1'b0},
			'{8'hBF, 1'b0, 1'b1, 21'h00FFFF, 1'b1},  // top of three-byte range
			'{8'hF7, 1'b0, 1'b1, 21'h000000, 1'b0},
			'{8'hBF, 1'b0, 1'b1, 21'h000000, 1'b0},
			'{8'hBF, 1'b0, 1'b1, 21'h000000, 1'b0},
			'{8'hBF, 1'b0, 1'b1, 21'h1FFFFF, 1'b1},  // all 21 bits set
			'{8'hF0, 1'b0, 1'b0, 21'h000000, 1'b0},  // ordinary four-byte point
			'{8'h9F, 1'b0, 1'b0, 21'h000000, 1'b0},
			'{8'h98, 1'b0, 1'b0, 21'h000000, 1'b0},
			'{8'h80, 1'b0, 1'b0, 21'h000000, 1'b0},
			'{8'hE2, 1'b0, 1'b1, 21'h000000, 1'b0},  // malformed continuation
			'{8'h41, 1'b0, 1'b1, 21'h000000, 1'b0},  // consumed, marks sequence bad
			'{8'h82, 1'b0, 1'b1, 21'h000000, 1'b0},  // finishes it, nothing emitted
			'{8'hE2, 1'b0, 1'b1, 21'h000000, 1'b0},
			'{8'h82, 1'b1, 1'b1, 21'h000000, 1'b0},  // string ends mid-sequence
			'{8'h41, 1'b1, 1'b1, 21'h000041, 1'b1}   // clean start after the cut
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_COUNT; i++) begin
			fixed.code_point  = probe_rows[i].point;
			fixed.point_valid = probe_rows[i].valid;
			fixed.string_end  = probe_rows[i].last;
			send_word(probe_rows[i].data, probe_rows[i].last, fixed, probe_rows[i].known);
		end

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			fill_string();
			foreach (text_bytes[k]) begin
				send_word(text_bytes[k], k == text_bytes.size() - 1, '0, 1'b0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		// let the last results out before finishing
		while (expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("utf8_stream_decoder test passed");
		else
			$display("utf8_stream_decoder test failed");
		$finish;
	end

	// Receiver: ready in random bursts with random stalls in between.
	initial begin
		int gap;
		m_tready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat (quiet_out ? 1 : $urandom_range(1, 20)) @(posedge clk);
			gap = quiet_out ? 0 : pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Switch idling on and off now and then on each side.
	initial begin
		forever begin
			repeat (300) @(posedge clk);
			quiet_in  <= ($urandom_range(0, 3) == 0);
			quiet_out <= ($urandom_range(0, 3) == 0);
		end
	end

	// Compare every result word with the oldest expectation.
	always @(posedge clk) begin
		utf8sd_pkg::dec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$error("result word with no expectation waiting");
				fail_count++;
			end else begin
				want = expected_words.pop_front();
				if (m_tdata[utf8sd_pkg::POINT_W-1:0] !== want.code_point) begin
					$error("code_point: expected %h, got %h", want.code_point,
						m_tdata[utf8sd_pkg::POINT_W-1:0]);
					fail_count++;
				end
				if (m_tuser[0] !== want.point_valid) begin
					$error("point_valid: expected %b, got %b", want.point_valid, m_tuser[0]);
					fail_count++;
				end
				if (m_tlast !== want.string_end) begin
					$error("string_end: expected %b, got %b", want.string_end, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#(5_000_000);
		$display("utf8_stream_decoder test failed");
		$finish;
	end

endmodule
